/* src/bce_pkg.sv */
`default_nettype none
package bce_pkg;

  // field and internal widths
  localparam int unsigned CntW   = 13;
  localparam int unsigned LnW    = 22;
  localparam int unsigned AccW   = 40;
  localparam int unsigned NumW   = 64;
  localparam int unsigned DenW   = 44;
  localparam int unsigned LnIters = 30;

  // command codes
  localparam logic [1:0] CMD_FWD   = 2'd0;
  localparam logic [1:0] CMD_PGRAD = 2'd1;
  localparam logic [1:0] CMD_LGRAD = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  // ln(2) in Q.28
  localparam logic [27:0] LN2_Q28 = 28'd186065280;

  // controller to datapath
  typedef struct packed {
    logic cap;
    logic st_a;
    logic st_b;
    logic st_c;
    logic div_go;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ln_done;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

/* src/bce_ln.sv */
`default_nettype none
module bce_ln import bce_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [16:0]           x_i,
  output logic                       done_o,
  output logic signed [LnW-1:0]      ln_o
);

  logic              busy_q;
  logic [4:0]        cnt_q;
  logic [31:0]       m_q;
  logic [LnIters-1:0] frac_q;
  logic signed [33:0] kt_q;
  logic [57:0]       prod_q;
  logic signed [LnW-1:0] ln_q;
  logic              done_q;

  logic [4:0]        k;
  logic signed [5:0] ke;
  logic signed [33:0] kt;
  logic [31:0]       m_init;
  logic [63:0]       sq;
  logic signed [63:0] v;

  // leading-one position
  always_comb begin
    k = 5'd0;
    for (int i = 0; i < 17; i++) begin
      if (x_i[i]) k = 5'(i);
    end
  end

  assign ke     = $signed({1'b0, k}) - 6'sd16;
  assign kt     = 34'(ke) * $signed({6'b0, LN2_Q28});
  assign m_init = {15'b0, x_i} << (5'd31 - k);
  assign sq     = m_q * m_q;
  assign v      = $signed({6'b0, prod_q}) + (64'(kt_q) <<< 30) + 64'sh200_0000_0000;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 5'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // squaring steps, then scale by ln2 and round
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      m_q    <= m_init;
      frac_q <= '0;
      kt_q   <= kt;
    end else if (busy_q) begin
      if (cnt_q < 5'(LnIters)) begin
        m_q    <= sq[63] ? sq[63:32] : sq[62:31];
        frac_q <= {frac_q[LnIters-2:0], sq[63]};
      end else if (cnt_q == 5'(LnIters)) begin
        prod_q <= frac_q * LN2_Q28;
      end else begin
        ln_q <= v[63:42];
      end
    end
  end

  assign done_o = done_q;
  assign ln_o   = ln_q;

endmodule
`default_nettype wire

/* src/bce_div.sv */
`default_nettype none
module bce_div import bce_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic                 done_o,
  output logic [NumW-1:0]      quo_o
);

  logic              busy_q;
  logic [5:0]        cnt_q;
  logic              done_q;
  logic [DenW-1:0]   rem_q;
  logic [DenW-1:0]   den_q;
  logic [NumW-1:0]   quo_q;
  logic [DenW:0]     sh;
  logic [DenW:0]     diff;
  logic              ge;

  // one restoring step per cycle
  assign sh   = {rem_q, quo_q[NumW-1]};
  assign ge   = sh >= {1'b0, den_q};
  assign diff = sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 6'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DenW-1:0] : sh[DenW-1:0];
      quo_q <= {quo_q[NumW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

/* src/bce_dp.sv */
`default_nettype none
module bce_dp import bce_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire dp_cmd_t             ctl_i,
  output dp_stat_t                 stat_o,
  input  wire logic [CntW-1:0]     n_i,
  input  wire logic [1:0]          cmd_i,
  input  wire logic [15:0]         label_i,
  input  wire logic [15:0]         prob_i,
  input  wire logic signed [31:0]  upstream_grad_i,
  input  wire logic                last_i,
  input  wire logic                out_ready_i,
  output logic                     out_valid_o,
  output logic signed [31:0]       value_o,
  output logic                     last_out_o,
  output logic                     saturated_o
);

  // captured word
  logic [1:0]         cmd_q;
  logic [15:0]        y_q;
  logic [15:0]        p_q;
  logic signed [31:0] g_q;
  logic               last_q;

  // stage registers
  logic signed [AccW-1:0] pa_q, pb_q, term_q;
  logic [31:0]        pp_q;
  logic [30:0]        dpp_q;
  logic signed [22:0] dl_q;
  logic [53:0]        prod_q;
  logic               neg_q;
  logic [NumW-1:0]    num_q;
  logic [DenW-1:0]    den_q;
  logic signed [AccW-1:0] acc_q;

  // output register
  logic               out_valid_q;
  logic signed [31:0] value_q;
  logic               last_out_q;
  logic               sat_q;

  logic signed [LnW-1:0] lna, lnb;
  logic               lna_done, lnb_done, div_done;
  logic [NumW-1:0]    quo;
  logic [16:0]        xa, xb, yc, pc;
  logic signed [16:0] d;
  logic [15:0]        d_abs;
  logic [21:0]        dl_abs;
  logic [31:0]        g_abs;
  logic [21:0]        da;
  logic               gneg, dneg, dzero;
  logic signed [AccW:0] acc_sum;
  logic signed [AccW-1:0] acc_sat;
  logic [AccW-1:0]    acc_mag;
  logic [NumW-1:0]    div_num;
  logic [DenW-1:0]    div_den;
  logic               clip_sat;
  logic signed [31:0] clip_val;

  assign xa = {1'b0, prob_i} + 17'd1;
  assign xb = 17'd65537 - {1'b0, prob_i};

  bce_ln u_ln_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl_i.cap),
    .x_i     (xa),
    .done_o  (lna_done),
    .ln_o    (lna)
  );

  bce_ln u_ln_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl_i.cap),
    .x_i     (xb),
    .done_o  (lnb_done),
    .ln_o    (lnb)
  );

  // operand prep
  assign yc     = 17'd65536 - {1'b0, y_q};
  assign pc     = 17'd65536 - {1'b0, p_q};
  assign d      = $signed({1'b0, p_q}) - $signed({1'b0, y_q});
  assign d_abs  = d[16] ? 16'(-d) : d[15:0];
  assign dl_abs = dl_q[22] ? 22'(-dl_q) : dl_q[21:0];
  assign g_abs  = g_q[31] ? (32'd0 - g_q) : g_q;
  assign gneg   = g_q[31];
  assign dneg   = (cmd_q == CMD_PGRAD) ? d[16] : dl_q[22];
  assign dzero  = (cmd_q == CMD_PGRAD) ? (d == 17'sd0) : (dl_q == 23'sd0);
  assign da     = (cmd_q == CMD_PGRAD) ? {6'b0, d_abs} : dl_abs;

  // accumulator add with clamp
  assign acc_sum = (AccW+1)'(acc_q) + (AccW+1)'(term_q);
  always_comb begin
    if (acc_sum[AccW] != acc_sum[AccW-1]) begin
      acc_sat = acc_sum[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[AccW-1:0];
    end
  end

  // divider operands, rounding offset folded in
  assign acc_mag = acc_q[AccW-1] ? (AccW'(0) - acc_q) : acc_q;
  always_comb begin
    if (cmd_q == CMD_FWD) begin
      div_den = DenW'(n_i);
      div_num = NumW'(acc_mag) + NumW'(n_i >> 1);
    end else begin
      div_den = den_q;
      div_num = num_q + NumW'(den_q >> 1);
    end
  end

  bce_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl_i.div_go),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // sign and clip
  always_comb begin
    clip_sat = 1'b0;
    if (neg_q) begin
      if (quo > NumW'(64'h8000_0000)) begin
        clip_sat = 1'b1;
        clip_val = 32'sh8000_0000;
      end else begin
        clip_val = 32'd0 - quo[31:0];
      end
    end else begin
      if (quo > NumW'(64'h7FFF_FFFF)) begin
        clip_sat = 1'b1;
        clip_val = 32'sh7FFF_FFFF;
      end else begin
        clip_val = quo[31:0];
      end
    end
  end

  // capture and stage registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.cap) begin
      cmd_q  <= cmd_i;
      y_q    <= label_i;
      p_q    <= prob_i;
      g_q    <= upstream_grad_i;
      last_q <= last_i;
    end
    if (ctl_i.st_a) begin
      pa_q <= AccW'($signed({1'b0, y_q})) * AccW'(lna);
      pb_q <= AccW'($signed({1'b0, yc})) * AccW'(lnb);
      pp_q <= 32'(p_q) * 32'(pc);
      dl_q <= 23'(lnb) - 23'(lna);
    end
    if (ctl_i.st_b) begin
      term_q <= (pa_q + pb_q + AccW'(32'sd32768)) >>> 16;
      prod_q <= 54'(g_abs) * 54'(da);
      dpp_q  <= 31'(pp_q) + 31'd65536;
      neg_q  <= (gneg != dneg) && (g_q != 32'sd0) && !dzero;
    end
    if (ctl_i.st_c) begin
      if (cmd_q == CMD_PGRAD) begin
        den_q <= DenW'(dpp_q) * DenW'(n_i);
        num_q <= {prod_q[47:0], 16'b0};
      end else begin
        den_q <= {15'b0, n_i, 16'b0};
        num_q <= NumW'(prod_q);
      end
    end
    if (ctl_i.div_go && cmd_q == CMD_FWD) begin
      neg_q <= !acc_q[AccW-1] && (acc_q != '0);
    end
    if (ctl_i.out_load) begin
      value_q    <= clip_val;
      sat_q      <= clip_sat;
      last_out_q <= (cmd_q == CMD_FWD) ? 1'b1 : last_q;
    end
  end

  // loss accumulator and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_i.st_c && cmd_q == CMD_FWD) begin
        acc_q <= acc_sat;
      end else if (ctl_i.div_go && cmd_q == CMD_FWD) begin
        acc_q <= '0;
      end
      if (ctl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.ln_done  = lna_done & lnb_done;
  assign stat_o.div_done = div_done;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign last_out_o  = last_out_q;
  assign saturated_o = sat_q;

endmodule
`default_nettype wire

/* src/bce_ctrl.sv */
`default_nettype none
module bce_ctrl import bce_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [1:0] cmd_i,
  input  wire logic       last_i,
  output logic            in_ready_o,
  input  wire dp_stat_t   stat_i,
  output dp_cmd_t         ctl_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_LN, S_A, S_B, S_C, S_D, S_DIV, S_DONE
  } state_e;

  state_e state_q;
  logic   fwd_q;
  logic   last_q;
  logic   accept;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_ready_o = (state_q == S_IDLE);

  // command decode
  always_comb begin
    ctl_o          = '0;
    ctl_o.cap      = accept && (cmd_i != CMD_NONE);
    ctl_o.st_a     = (state_q == S_A);
    ctl_o.st_b     = (state_q == S_B);
    ctl_o.st_c     = (state_q == S_C);
    ctl_o.div_go   = (state_q == S_D);
    ctl_o.out_load = (state_q == S_DONE) && stat_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fwd_q   <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept && cmd_i != CMD_NONE) begin
            fwd_q   <= (cmd_i == CMD_FWD);
            last_q  <= last_i;
            state_q <= S_LN;
          end
        end
        S_LN: begin
          if (stat_i.ln_done) state_q <= S_A;
        end
        S_A: state_q <= S_B;
        S_B: state_q <= S_C;
        S_C: begin
          // forward word without last only updates the sum
          if (fwd_q && !last_q) state_q <= S_IDLE;
          else state_q <= S_D;
        end
        S_D: state_q <= S_DIV;
        S_DIV: begin
          if (stat_i.div_done) state_q <= S_DONE;
        end
        S_DONE: begin
          if (stat_i.out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* src/binary_cross_entropy_loss_top.sv */
// Flow: a forward word without last runs the two log units, then stages A, B and C,
//   and only updates the sum; a forward last or gradient word goes on through stage D
//   and the divider, and its result is loaded once the output register is free.
// Throughput: one word at a time; the log units and the 64-step
//   bit-serial divider set the pace. A dropped command leaves the block idle.
// Reset: asynchronous, active low; clears the sum, count register to 1, no result.
`default_nettype none
module binary_cross_entropy_loss_top import bce_pkg::*; #(
  parameter int unsigned MaxElements = 4096
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CntW-1:0]     cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [1:0]          cmd_i,
  input  wire logic [15:0]         label_i,
  input  wire logic [15:0]         prob_i,
  input  wire logic signed [31:0]  upstream_grad_i,
  input  wire logic                last_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic signed [31:0]       value_o,
  output logic                     last_out_o,
  output logic                     saturated_o
);

  logic [CntW-1:0] count_q;
  logic [CntW-1:0] n_eff;
  dp_cmd_t         ctl;
  dp_stat_t        stat;

  // element count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CntW'(1);
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  // effective divisor
  always_comb begin
    if (count_q == '0) begin
      n_eff = CntW'(1);
    end else if (32'(count_q) > MaxElements) begin
      n_eff = CntW'(MaxElements);
    end else begin
      n_eff = count_q;
    end
  end

  bce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .last_i     (last_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  bce_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .stat_o          (stat),
    .n_i             (n_eff),
    .cmd_i           (cmd_i),
    .label_i         (label_i),
    .prob_i          (prob_i),
    .upstream_grad_i (upstream_grad_i),
    .last_i          (last_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .value_o         (value_o),
    .last_out_o      (last_out_o),
    .saturated_o     (saturated_o)
  );

endmodule
`default_nettype wire

/* src/bce_chk.sv */
`default_nettype none
module bce_chk import bce_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [1:0]  cmd_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] value_o,
  input wire logic        saturated_o
);

  // a real word holds off the input while it is worked on
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && cmd_i != CMD_NONE) |=> !in_ready_o)
    else $error("input ready right after a word was taken");

  // a result never appears in the cycle after an input word
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_valid_i && in_ready_o))
    else $error("result too soon after input");

  // a clipped value sits at a rail
  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |-> (value_o == 32'h7FFF_FFFF || value_o == 32'h8000_0000))
    else $error("saturated flag off the rail");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(value_o)))
    else $error("stalled result changed");

endmodule

bind binary_cross_entropy_loss_top bce_chk u_bce_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .cmd_i       (cmd_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .value_o     (value_o),
  .saturated_o (saturated_o)
);
`default_nettype wire
